>>> hdl/itar_pkg.sv
// ----------------------------------------------------------------------------
// itar_pkg: shared constants for the integer to ASCII converter
// Character codes, radix limits, register indexes and the digit to
// character mapping.
// ----------------------------------------------------------------------------
package itar_pkg;

  localparam logic [6:0] CH_MINUS    = 7'h2D;
  localparam logic [6:0] CH_ZERO     = 7'h30;
  localparam logic [6:0] CH_LETTER_A = 7'h41;

  localparam logic [4:0] RADIX_MIN   = 5'd2;
  localparam logic [4:0] RADIX_MAX   = 5'd16;
  localparam logic [4:0] RADIX_RESET = 5'd10;

  localparam int unsigned CFG_WIDTH = 5;

  // configuration register indexes
  localparam logic REG_RADIX  = 1'b0;
  localparam logic REG_SIGNED = 1'b1;

  // digit value 0..15 to '0'..'9', 'A'..'F'
  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] d7;
    d7 = {3'b000, d};
    if (d < 4'd10) begin
      return CH_ZERO + d7;
    end
    return CH_LETTER_A + d7 - 7'd10;
  endfunction

endpackage

>>> hdl/itar_ram.sv
// ----------------------------------------------------------------------------
// itar_ram: generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module itar_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/itar_div.sv
// ----------------------------------------------------------------------------
// itar_div: bit-serial divider by a small radix
// Restoring division, one dividend bit per cycle; done pulses once all
// VALUE_WIDTH dividend bits have been shifted through. Quotient and remainder
// hold after done until the next start.
// ----------------------------------------------------------------------------
module itar_div
  import itar_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [4:0]             base,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [3:0]             remainder
);

  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH);

  logic                   busy;
  logic [CNT_W-1:0]       cnt;
  logic [VALUE_WIDTH-1:0] quo;
  logic [3:0]             rem;
  logic [4:0]             rem_sh;
  logic                   q_bit;
  logic [4:0]             rem_diff;

  // partial remainder stays below base, so 4 bits plus the shifted-in bit
  assign rem_sh   = {rem, quo[VALUE_WIDTH-1]};
  assign q_bit    = (rem_sh >= base);
  assign rem_diff = rem_sh - base;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        quo  <= dividend;
        rem  <= 4'd0;
        cnt  <= CNT_W'(VALUE_WIDTH - 1);
      end else if (busy) begin
        quo <= {quo[VALUE_WIDTH-2:0], q_bit};
        rem <= q_bit ? rem_diff[3:0] : rem_sh[3:0];
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CNT_W'(1);
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

>>> hdl/int_to_ascii_radix.sv
// ----------------------------------------------------------------------------
// int_to_ascii_radix: integer to ASCII text in base 2 to 16
// Converts one integer per request into its digits, most significant first,
// one character per output request, with a minus sign for negative values.
// ----------------------------------------------------------------------------
// One request in gives its text out as a stream of 7-bit ASCII characters
// ('-', '0'..'9', 'A'..'F'), tlast on the final one. A single shared
// bit-serial divider produces the digits least significant first into a
// small RAM; they are then read back in reverse. Each digit takes a full
// pass through the divider; emitting the characters can stall on m_tready
// backpressure. No new request is taken until the last character of the
// current one has been loaded for output: s_tready is high only while the
// block is idle. radix saturates into 2..16; signed_mode = 1 reads the low
// 32 bits as two's complement, 0 reads VALUE_WIDTH bits unsigned. A number
// with more than DIGIT_DEPTH digits keeps only its DIGIT_DEPTH low digits.
// Configuration must only be written while no conversion is in flight;
// the block itself does not enforce this.
module int_to_ascii_radix
  import itar_pkg::*;
#(
  parameter int unsigned DIGIT_DEPTH = 64,
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_data,
  // input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [63:0]          s_tdata,   // [63:0] value
  // output stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // [6:0] ascii_char, [7] zero pad
  output logic                 m_tlast    // last character of the number
);

  localparam int unsigned AW = $clog2(DIGIT_DEPTH);
  localparam int unsigned CW = $clog2(DIGIT_DEPTH + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;  // divider producing digits
  localparam logic [2:0] S_SIGN = 3'd2;  // emit '-'
  localparam logic [2:0] S_RD   = 3'd3;  // address digit RAM
  localparam logic [2:0] S_OUT  = 3'd4;  // emit digit

  logic [2:0]    state;
  logic [CW-1:0] count;      // digits stored; counts down while emitting
  logic [CW-1:0] cnt_dec;
  logic          negative;
  logic [4:0]    radix;
  logic          signed_mode;
  logic [4:0]    base;

  logic [6:0]    out_char;

  // request decode
  logic [31:0]            low_word;
  logic                   neg_in;
  logic [31:0]            mag32;
  logic [VALUE_WIDTH-1:0] mag_in;

  // divider hookup
  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quotient;
  logic [3:0]             div_remainder;
  logic                   div_last;

  // digit RAM
  logic          ram_we;
  logic [3:0]    ram_rdata;

  logic          out_free;
  logic          load_sign;
  logic          load_digit;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      radix       <= RADIX_RESET;
      signed_mode <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIX:  radix       <= cfg_data;
        REG_SIGNED: signed_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // out-of-range radix acts as the nearest limit
  always_comb begin
    if (radix < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = radix;
    end
  end

  // ------------------------------------------------------ magnitude select
  assign low_word = s_tdata[31:0];
  assign neg_in   = signed_mode & low_word[31];
  assign mag32    = neg_in ? (~low_word + 32'd1) : low_word;
  assign mag_in   = signed_mode ? VALUE_WIDTH'(mag32) : s_tdata[VALUE_WIDTH-1:0];

  // ------------------------------------------------------------- divider
  // Do-while over digits: a zero value still yields one '0' digit.
  // Stop on zero quotient or once the store is full.
  assign div_last  = (div_quotient == '0) || (count == CW'(DIGIT_DEPTH - 1));
  assign s_tready  = (state == S_IDLE);
  assign div_start = (s_tready && s_tvalid) ||
                     (state == S_DIV && div_done && !div_last);
  assign div_dividend = (state == S_IDLE) ? mag_in : div_quotient;

  itar_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .base      (base),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  // ----------------------------------------------------------- digit RAM
  assign ram_we  = (state == S_DIV) && div_done;
  assign cnt_dec = count - CW'(1);

  itar_ram #(
    .WIDTH(4),
    .DEPTH(DIGIT_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (div_remainder),
    .raddr (cnt_dec[AW-1:0]),
    .rdata (ram_rdata)
  );

  // ----------------------------------------------------------- sequencer
  assign out_free   = !m_tvalid || m_tready;
  assign load_sign  = (state == S_SIGN) && out_free;
  assign load_digit = (state == S_OUT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      negative <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            negative <= neg_in;
            count    <= '0;
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            count <= count + CW'(1);
            if (div_last) begin
              state <= negative ? S_SIGN : S_RD;
            end
          end
        end
        S_SIGN: begin
          if (out_free) begin
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            count <= cnt_dec;
            state <= (count == CW'(1)) ? S_IDLE : S_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ------------------------------------------------------ output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_sign || load_digit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_sign) begin
      out_char <= CH_MINUS;
      m_tlast  <= 1'b0;
    end else if (load_digit) begin
      out_char <= digit_char(ram_rdata);
      m_tlast  <= (count == CW'(1));
    end
  end

  assign m_tdata = {1'b0, out_char};

  // ---------------------------------------------------------- assertions
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside digit generation");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DIGIT_DEPTH))
    else $error("digit count beyond store depth");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD || state == S_OUT || state == S_SIGN) |-> count != '0)
    else $error("emitting with no digits stored");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (load_digit && count == CW'(1)) |=> (state == S_IDLE && m_tvalid && m_tlast))
    else $error("final digit did not end the number");

endmodule
